FILE: rtl/jstv_pkg.sv
// ----------------------------------------------------------------------------
// jstv_pkg
// Shared types and constants of the JSON stream tokenizer/validator.
// ----------------------------------------------------------------------------
package jstv_pkg;

  localparam int STACK_DEPTH = 16;
  localparam int LVL_W = $clog2(STACK_DEPTH + 1);
  localparam int PTR_W = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int MAX_RES = 3;
  localparam int CNT_W = 2;

  typedef enum logic [3:0] {
    EV_OPEN_ARR = 4'd0,
    EV_OPEN_OBJ = 4'd1,
    EV_CLOSE    = 4'd2,
    EV_STR_BYTE = 4'd3,
    EV_STR_END  = 4'd4,
    EV_NUMBER   = 4'd5,
    EV_TRUE     = 4'd6,
    EV_FALSE    = 4'd7,
    EV_NULL     = 4'd8,
    EV_ERROR    = 4'd9,
    EV_DOC_END  = 4'd10
  } event_t;

  typedef enum logic [2:0] {
    PS_EMPTY  = 3'd0,
    PS_VALUE  = 3'd1,
    PS_ARRAY  = 3'd2,
    PS_OBJKEY = 3'd3,
    PS_OBJVAL = 3'd4,
    PS_BAD    = 3'd5
  } pstate_t;

  typedef enum logic [2:0] {
    COL_COMMA = 3'd0,
    COL_STR   = 3'd1,
    COL_INT   = 3'd2,
    COL_ARR   = 3'd3,
    COL_OBJ   = 3'd4
  } col_t;

  typedef enum logic [3:0] {
    LX_IDLE  = 4'd0,
    LX_STR   = 4'd1,
    LX_ESC   = 4'd2,
    LX_NUM   = 4'd3,
    LX_LIT   = 4'd4,
    LX_SLASH = 4'd5,
    LX_LINE  = 4'd6,
    LX_BLOCK = 4'd7,
    LX_STAR  = 4'd8
  } lexmode_t;

  typedef struct packed {
    logic [3:0]  kind;
    logic [7:0]  ch;
    logic        key;
    logic [31:0] num;
    logic [4:0]  level;
  } res_t;

  function automatic logic [2:0] next_state(input logic [2:0] ps, input col_t col);
    logic [2:0] r;
    r = PS_BAD;
    case (ps)
      PS_EMPTY, PS_ARRAY: begin
        case (col)
          COL_STR, COL_INT: r = PS_VALUE;
          COL_ARR: r = PS_ARRAY;
          COL_OBJ: r = PS_OBJKEY;
          default: r = PS_BAD;
        endcase
      end
      PS_VALUE: r = (col == COL_COMMA) ? 3'(PS_EMPTY) : 3'(PS_BAD);
      PS_OBJKEY: begin
        case (col)
          COL_COMMA, COL_OBJ: r = PS_OBJKEY;
          COL_STR: r = PS_OBJVAL;
          default: r = PS_BAD;
        endcase
      end
      PS_OBJVAL: begin
        case (col)
          COL_STR, COL_INT, COL_OBJ: r = PS_OBJKEY;
          COL_ARR: r = PS_ARRAY;
          default: r = PS_BAD;
        endcase
      end
      default: r = PS_BAD;
    endcase
    return r;
  endfunction

  // lowercase letter of literal sel at position pos; zero where none
  function automatic logic [7:0] lit_char(input logic [1:0] sel, input logic [2:0] pos);
    logic [7:0] r;
    r = 8'h00;
    case (sel)
      2'd0: begin
        case (pos)
          3'd0: r = "t";
          3'd1: r = "r";
          3'd2: r = "u";
          3'd3: r = "e";
          default: r = 8'h00;
        endcase
      end
      2'd1: begin
        case (pos)
          3'd0: r = "f";
          3'd1: r = "a";
          3'd2: r = "l";
          3'd3: r = "s";
          3'd4: r = "e";
          default: r = 8'h00;
        endcase
      end
      2'd2: begin
        case (pos)
          3'd0: r = "n";
          3'd1: r = "u";
          3'd2: r = "l";
          3'd3: r = "l";
          default: r = 8'h00;
        endcase
      end
      default: r = 8'h00;
    endcase
    return r;
  endfunction

  function automatic logic [2:0] lit_len(input logic [1:0] sel);
    logic [2:0] r;
    case (sel)
      2'd0: r = 3'd4;
      2'd1: r = 3'd5;
      2'd2: r = 3'd4;
      default: r = 3'd0;
    endcase
    return r;
  endfunction

endpackage

FILE: rtl/json_stream_tokenizer_validator_top.sv
// ----------------------------------------------------------------------------
// json_stream_tokenizer_validator_top
// Byte-wide JSON tokenizer with bracket stack and syntax check.
// ----------------------------------------------------------------------------
// channel  dir  tdata                          tuser  tlast
// s_axis   in   [7:0] data_byte                -      end_of_document
// m_axis   out  kind,char,key,number,level     -      last
//
// One byte is taken per clock. Each byte is decoded into up to three events
// in a result buffer that drains one event per clock while m_axis_tready is
// high; a byte that makes one event or none keeps full rate. s_axis_tready
// drops only while the buffer holds events that will not drain this cycle.
// Reset (rst, synchronous) returns the parser to its empty state. The state
// stack has no reset; only entries below the level are read.
// ----------------------------------------------------------------------------
module json_stream_tokenizer_validator_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
  input  logic        s_axis_tlast,   // end_of_document
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [55:0] m_axis_tdata,   // [3:0] event_kind, [11:4] char_value,
                                      // [12] is_key, [44:13] number_value,
                                      // [49:45] nesting_level, [55:50] zero
  output logic        m_axis_tlast    // last
);

  localparam int LVL_W = jstv_pkg::LVL_W;

  logic [2:0]        parse_state;
  logic [2:0]        state_stack [jstv_pkg::STACK_DEPTH];
  logic [LVL_W-1:0]  stack_level;
  logic [3:0]        lexer_mode;
  logic [31:0]       number_accum;
  logic              number_negative;
  logic [1:0]        literal_select;
  logic [2:0]        literal_position;
  logic              error_latched;

  // result buffer: up to three events, head at index 0
  jstv_pkg::res_t       buf_q [jstv_pkg::MAX_RES];
  logic [jstv_pkg::CNT_W-1:0] buf_cnt;

  // next-state values
  logic [2:0]        ps_n;
  logic [LVL_W-1:0]  lvl_n;
  logic [3:0]        lx_n;
  logic [31:0]       acc_n;
  logic              neg_n;
  logic [1:0]        sel_n;
  logic [2:0]        pos_n;
  logic              err_n;
  logic              push_en;
  logic [2:0]        push_val;
  jstv_pkg::res_t    ev [jstv_pkg::MAX_RES];
  logic [jstv_pkg::CNT_W-1:0] ev_cnt;

  logic accept;
  logic pop;

  assign pop = m_axis_tvalid && m_axis_tready;
  assign s_axis_tready = (buf_cnt == '0) ||
                         (buf_cnt == jstv_pkg::CNT_W'(1) && m_axis_tready);
  assign accept = s_axis_tvalid && s_axis_tready;

  logic [2:0] top_val;
  assign top_val = state_stack[jstv_pkg::PTR_W'(stack_level - LVL_W'(1))];

  always_comb begin
    logic [7:0]  c;
    logic        eod;
    logic        key;
    logic        restart;
    logic        had_err;
    logic        bad;
    logic [7:0]  lc;
    logic [7:0]  m;
    logic        esc_ok;
    logic [2:0]  nx;
    logic [35:0] prod;
    logic [31:0] nval;
    logic        ws;
    c = s_axis_tdata;
    eod = s_axis_tlast;
    ps_n = parse_state; lvl_n = stack_level; lx_n = lexer_mode;
    acc_n = number_accum; neg_n = number_negative; sel_n = literal_select;
    pos_n = literal_position; err_n = error_latched;
    push_en = 1'b0; push_val = '0;
    ev_cnt = '0;
    for (int i = 0; i < jstv_pkg::MAX_RES; i++) ev[i] = '0;
    key = (parse_state == jstv_pkg::PS_OBJKEY);
    restart = 1'b0;
    lc = (c >= "A" && c <= "Z") ? c + 8'd32 : c;
    m = 8'h00; esc_ok = 1'b1;
    nx = '0; prod = '0; nval = '0; bad = 1'b0;
    ws = (c == " ") || (c >= 8'd9 && c <= 8'd13);
    had_err = 1'b0;

    if (!error_latched) begin
      case (lexer_mode)
        jstv_pkg::LX_STR: begin
          if (c == "\\") lx_n = jstv_pkg::LX_ESC;
          else if (c == "\"") begin
            ev[0] = '{jstv_pkg::EV_STR_END, 8'h00, key, 32'h0, 5'(stack_level)};
            ev_cnt = 2'd1;
            ps_n = jstv_pkg::next_state(parse_state, jstv_pkg::COL_STR);
            lx_n = jstv_pkg::LX_IDLE;
          end else begin
            ev[0] = '{jstv_pkg::EV_STR_BYTE, c, key, 32'h0, 5'(stack_level)};
            ev_cnt = 2'd1;
          end
        end
        jstv_pkg::LX_ESC: begin
          case (c)
            "\"": m = 8'h22;
            "\\": m = 8'h5C;
            "/":  m = 8'h2F;
            "b":  m = 8'h08;
            "f":  m = 8'h0C;
            "n":  m = 8'h0A;
            "r":  m = 8'h0D;
            "t":  m = 8'h09;
            default: esc_ok = 1'b0;
          endcase
          if (!esc_ok) begin
            err_n = 1'b1; lx_n = jstv_pkg::LX_IDLE;
            ev[0] = '{jstv_pkg::EV_ERROR, 8'h00, 1'b0, 32'h0, 5'(stack_level)};
            ev_cnt = 2'd1;
          end else begin
            ev[0] = '{jstv_pkg::EV_STR_BYTE, m, key, 32'h0, 5'(stack_level)};
            ev_cnt = 2'd1;
            lx_n = jstv_pkg::LX_STR;
          end
        end
        jstv_pkg::LX_NUM: begin
          if (c >= "0" && c <= "9") begin
            prod = {number_accum, 3'b000} + {2'b00, number_accum, 1'b0}
                   + 36'(c - "0");
            acc_n = (prod > 36'h080000000) ? 32'h80000000 : prod[31:0];
          end else begin
            nval = number_negative ? (32'h0 - number_accum) :
                   (number_accum > 32'h7FFFFFFF ? 32'h7FFFFFFF : number_accum);
            ev[0] = '{jstv_pkg::EV_NUMBER, 8'h00, 1'b0, nval, 5'(stack_level)};
            ev_cnt = 2'd1;
            ps_n = jstv_pkg::next_state(parse_state, jstv_pkg::COL_INT);
            lx_n = jstv_pkg::LX_IDLE;
            restart = 1'b1;
          end
        end
        jstv_pkg::LX_LIT: begin
          if (literal_position >= jstv_pkg::lit_len(literal_select) ||
              lc != jstv_pkg::lit_char(literal_select, literal_position)) begin
            err_n = 1'b1; lx_n = jstv_pkg::LX_IDLE;
            ev[0] = '{jstv_pkg::EV_ERROR, 8'h00, 1'b0, 32'h0, 5'(stack_level)};
            ev_cnt = 2'd1;
          end else begin
            pos_n = literal_position + 3'd1;
            if (pos_n == jstv_pkg::lit_len(literal_select)) begin
              ev[0] = '{4'(jstv_pkg::EV_TRUE) + {2'b00, literal_select}, 8'h00,
                        1'b0, 32'h0, 5'(stack_level)};
              ev_cnt = 2'd1;
              ps_n = jstv_pkg::next_state(parse_state, jstv_pkg::COL_INT);
              lx_n = jstv_pkg::LX_IDLE;
            end
          end
        end
        jstv_pkg::LX_SLASH: begin
          if (c == "/") lx_n = jstv_pkg::LX_LINE;
          else if (c == "*") lx_n = jstv_pkg::LX_BLOCK;
          else begin
            err_n = 1'b1; lx_n = jstv_pkg::LX_IDLE;
            ev[0] = '{jstv_pkg::EV_ERROR, 8'h00, 1'b0, 32'h0, 5'(stack_level)};
            ev_cnt = 2'd1;
          end
        end
        jstv_pkg::LX_LINE: if (c == 8'h0A || c == 8'h0D) lx_n = jstv_pkg::LX_IDLE;
        jstv_pkg::LX_BLOCK: if (c == "*") lx_n = jstv_pkg::LX_STAR;
        jstv_pkg::LX_STAR: begin
          if (c == "/") lx_n = jstv_pkg::LX_IDLE;
          else if (c != "*") lx_n = jstv_pkg::LX_BLOCK;
        end
        default: begin
          lx_n = jstv_pkg::LX_IDLE;
          restart = 1'b1;
        end
      endcase

      // token start, possibly after a number ended on this byte
      if (restart && !ws) begin
        if (c == "\"") begin
          if (jstv_pkg::next_state(ps_n, jstv_pkg::COL_STR) == jstv_pkg::PS_BAD)
            bad = 1'b1;
          else lx_n = jstv_pkg::LX_STR;
        end else if (c == "-" || (c >= "0" && c <= "9")) begin
          if (jstv_pkg::next_state(ps_n, jstv_pkg::COL_INT) == jstv_pkg::PS_BAD)
            bad = 1'b1;
          else begin
            lx_n = jstv_pkg::LX_NUM;
            neg_n = (c == "-");
            acc_n = (c == "-") ? 32'h0 : 32'(c - "0");
          end
        end else if (c == "[" || c == "{") begin
          nx = jstv_pkg::next_state(ps_n, (c == "[") ? jstv_pkg::COL_ARR
                                                     : jstv_pkg::COL_OBJ);
          if (nx == jstv_pkg::PS_BAD || stack_level >= LVL_W'(jstv_pkg::STACK_DEPTH))
            bad = 1'b1;
          else begin
            push_en = 1'b1;
            push_val = jstv_pkg::next_state(ps_n, jstv_pkg::COL_STR);
            lvl_n = stack_level + LVL_W'(1);
            ps_n = nx;
            ev[ev_cnt] = '{(c == "[") ? jstv_pkg::EV_OPEN_ARR : jstv_pkg::EV_OPEN_OBJ,
                           8'h00, 1'b0, 32'h0, 5'(lvl_n)};
            ev_cnt = ev_cnt + 2'd1;
          end
        end else if (c == "]" || c == "}") begin
          if (stack_level == '0) bad = 1'b1;
          else begin
            lvl_n = stack_level - LVL_W'(1);
            ps_n = top_val;
            ev[ev_cnt] = '{jstv_pkg::EV_CLOSE, 8'h00, 1'b0, 32'h0, 5'(lvl_n)};
            ev_cnt = ev_cnt + 2'd1;
          end
        end else if (c == ":") begin
          if (ps_n != jstv_pkg::PS_OBJVAL) bad = 1'b1;
        end else if (c == ",") begin
          nx = jstv_pkg::next_state(ps_n, jstv_pkg::COL_COMMA);
          if (nx == jstv_pkg::PS_BAD) bad = 1'b1;
          else ps_n = nx;
        end else if (lc == "t" || lc == "f" || lc == "n") begin
          if (jstv_pkg::next_state(ps_n, jstv_pkg::COL_INT) == jstv_pkg::PS_BAD)
            bad = 1'b1;
          else begin
            sel_n = (lc == "t") ? 2'd0 : (lc == "f") ? 2'd1 : 2'd2;
            pos_n = 3'd1;
            lx_n = jstv_pkg::LX_LIT;
          end
        end else if (c == "/") begin
          lx_n = jstv_pkg::LX_SLASH;
        end else begin
          bad = 1'b1;
        end
        if (bad) begin
          err_n = 1'b1; lx_n = jstv_pkg::LX_IDLE;
          ev[ev_cnt] = '{jstv_pkg::EV_ERROR, 8'h00, 1'b0, 32'h0, 5'(stack_level)};
          ev_cnt = ev_cnt + 2'd1;
        end
      end
    end

    if (eod) begin
      had_err = err_n;
      bad = 1'b0;
      if (!had_err) begin
        if (lx_n == jstv_pkg::LX_NUM) begin
          nval = neg_n ? (32'h0 - acc_n) :
                 (acc_n > 32'h7FFFFFFF ? 32'h7FFFFFFF : acc_n);
          ev[ev_cnt] = '{jstv_pkg::EV_NUMBER, 8'h00, 1'b0, nval, 5'(lvl_n)};
          ev_cnt = ev_cnt + 2'd1;
        end else if (lx_n == jstv_pkg::LX_STR || lx_n == jstv_pkg::LX_ESC ||
                     lx_n == jstv_pkg::LX_LIT || lx_n == jstv_pkg::LX_SLASH)
          bad = 1'b1;
        if (lvl_n != '0) bad = 1'b1;
      end
      ev[ev_cnt] = '{(!had_err && bad) ? jstv_pkg::EV_ERROR : jstv_pkg::EV_DOC_END,
                     8'h00, 1'b0, 32'h0, 5'd0};
      ev_cnt = ev_cnt + 2'd1;
      ps_n = jstv_pkg::PS_EMPTY; lvl_n = '0; lx_n = jstv_pkg::LX_IDLE;
      acc_n = '0; neg_n = 1'b0; sel_n = '0; pos_n = '0; err_n = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      parse_state <= jstv_pkg::PS_EMPTY;
      stack_level <= '0;
      lexer_mode <= jstv_pkg::LX_IDLE;
      number_accum <= '0;
      number_negative <= 1'b0;
      literal_select <= '0;
      literal_position <= '0;
      error_latched <= 1'b0;
    end else if (accept) begin
      parse_state <= ps_n;
      stack_level <= lvl_n;
      lexer_mode <= lx_n;
      number_accum <= acc_n;
      number_negative <= neg_n;
      literal_select <= sel_n;
      literal_position <= pos_n;
      error_latched <= err_n;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && push_en)
      state_stack[jstv_pkg::PTR_W'(stack_level)] <= push_val;
  end

  // result buffer; accept only happens when it is empty or drains now
  always_ff @(posedge clk) begin
    if (rst) begin
      buf_cnt <= '0;
    end else if (accept) begin
      buf_cnt <= ev_cnt;
    end else if (pop) begin
      buf_cnt <= buf_cnt - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      for (int i = 0; i < jstv_pkg::MAX_RES; i++) buf_q[i] <= ev[i];
    end else if (pop) begin
      buf_q[0] <= buf_q[1];
      buf_q[1] <= buf_q[2];
    end
  end

  assign m_axis_tvalid = (buf_cnt != '0);
  assign m_axis_tlast  = (buf_cnt == 2'd1);
  assign m_axis_tdata  = {6'b0, buf_q[0].level, buf_q[0].num, buf_q[0].key,
                          buf_q[0].ch, buf_q[0].kind};

`ifndef SYNTHESIS
  a_stack_bound: assert property (@(posedge clk) disable iff (rst)
    stack_level <= LVL_W'(jstv_pkg::STACK_DEPTH))
    else $error("stack level beyond depth");
  a_cnt_bound: assert property (@(posedge clk) disable iff (rst)
    buf_cnt <= 2'd3)
    else $error("result count out of range");
  a_eod_clears: assert property (@(posedge clk) disable iff (rst)
    accept && s_axis_tlast |=> stack_level == '0 && !error_latched)
    else $error("state not cleared at end of document");
  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    buf_cnt > 2'd1 |-> !s_axis_tready)
    else $error("input taken while results pending");
`endif

endmodule

FILE: tb/json_stream_tokenizer_validator_top_test.sv
// ----------------------------------------------------------------------------
// json_stream_tokenizer_validator_top_test
// Self-checking bench: feeds JSON text bytes, predicts the token events
// with a behavioral parser, and compares every output transaction in order.
// ----------------------------------------------------------------------------
module json_stream_tokenizer_validator_top_test;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [3:0]  kind;
    logic [7:0]  ch;
    logic        key;
    logic [31:0] num;
    logic [4:0]  level;
    logic        last;
  } token_event_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = '0;
  logic        s_axis_tlast = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [55:0] m_axis_tdata;
  logic        m_axis_tlast;

  json_stream_tokenizer_validator_top dut (.*);

  always #10 clk = ~clk;

  // parser model state
  jstv_pkg::pstate_t  p_state;
  logic [2:0]         p_stack [jstv_pkg::STACK_DEPTH];
  int                 p_level;
  jstv_pkg::lexmode_t p_mode;
  logic [35:0]        p_accum;
  logic               p_neg;
  int                 p_lit_sel;
  int                 p_lit_pos;
  logic               p_err;

  token_event_t expected_events[$];
  token_event_t step_events[$];
  int errors = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  bit recv_hold = 0;
  longint cycles = 0;

  task automatic report(string what, token_event_t got, token_event_t want);
    errors++;
    $display({"mismatch %s: got kind=%0d ch=%h key=%b num=%0d lvl=%0d last=%b, ",
              "want kind=%0d ch=%h key=%b num=%0d lvl=%0d last=%b"},
             what, got.kind, got.ch, got.key, $signed(got.num), got.level, got.last,
             want.kind, want.ch, want.key, $signed(want.num), want.level, want.last);
  endtask

  function automatic jstv_pkg::pstate_t follow(jstv_pkg::pstate_t ps, jstv_pkg::col_t col);
    case (ps)
      jstv_pkg::PS_EMPTY, jstv_pkg::PS_ARRAY:
        case (col)
          jstv_pkg::COL_STR, jstv_pkg::COL_INT: return jstv_pkg::PS_VALUE;
          jstv_pkg::COL_ARR: return jstv_pkg::PS_ARRAY;
          jstv_pkg::COL_OBJ: return jstv_pkg::PS_OBJKEY;
          default: return jstv_pkg::PS_BAD;
        endcase
      jstv_pkg::PS_VALUE:
        return (col == jstv_pkg::COL_COMMA) ? jstv_pkg::PS_EMPTY : jstv_pkg::PS_BAD;
      jstv_pkg::PS_OBJKEY:
        case (col)
          jstv_pkg::COL_COMMA, jstv_pkg::COL_OBJ: return jstv_pkg::PS_OBJKEY;
          jstv_pkg::COL_STR: return jstv_pkg::PS_OBJVAL;
          default: return jstv_pkg::PS_BAD;
        endcase
      jstv_pkg::PS_OBJVAL:
        case (col)
          jstv_pkg::COL_STR, jstv_pkg::COL_INT, jstv_pkg::COL_OBJ: return jstv_pkg::PS_OBJKEY;
          jstv_pkg::COL_ARR: return jstv_pkg::PS_ARRAY;
          default: return jstv_pkg::PS_BAD;
        endcase
      default: return jstv_pkg::PS_BAD;
    endcase
  endfunction

  function automatic void add_event(jstv_pkg::event_t k, logic [7:0] c, logic key,
                                    logic [31:0] n);
    token_event_t e;
    if (step_events.size() >= jstv_pkg::MAX_RES) return;
    e.kind = k; e.ch = c; e.key = key; e.num = n;
    e.level = 5'(p_level); e.last = 1'b0;
    step_events = {step_events, e};
  endfunction

  function automatic void clear_parser();
    p_state = jstv_pkg::PS_EMPTY; p_level = 0; p_mode = jstv_pkg::LX_IDLE; p_accum = '0;
    p_neg = 0; p_lit_sel = 0; p_lit_pos = 0; p_err = 0;
  endfunction

  function automatic void flag_error();
    p_err = 1; p_mode = jstv_pkg::LX_IDLE;
    add_event(jstv_pkg::EV_ERROR, 8'h00, 1'b0, 32'd0);
  endfunction

  function automatic void emit_value();
    logic [31:0] v;
    if (p_neg) v = 32'd0 - p_accum[31:0];
    else v = (p_accum > 36'h7FFFFFFF) ? 32'h7FFFFFFF : p_accum[31:0];
    add_event(jstv_pkg::EV_NUMBER, 8'h00, 1'b0, v);
  endfunction

  function automatic void open_nest(jstv_pkg::col_t col, jstv_pkg::event_t k);
    jstv_pkg::pstate_t nx = follow(p_state, col);
    if (nx == jstv_pkg::PS_BAD || p_level >= jstv_pkg::STACK_DEPTH) begin
      flag_error();
      return;
    end
    p_stack[p_level] = follow(p_state, jstv_pkg::COL_STR);
    p_level++;
    p_state = nx;
    add_event(k, 8'h00, 1'b0, 32'd0);
  endfunction

  function automatic void begin_token(logic [7:0] c);
    jstv_pkg::pstate_t nx;
    if (c == " " || (c >= 8'd9 && c <= 8'd13)) return;
    if (c == "\"") begin
      if (follow(p_state, jstv_pkg::COL_STR) == jstv_pkg::PS_BAD) flag_error();
      else p_mode = jstv_pkg::LX_STR;
    end else if (c == "-" || (c >= "0" && c <= "9")) begin
      if (follow(p_state, jstv_pkg::COL_INT) == jstv_pkg::PS_BAD) flag_error();
      else begin
        p_mode = jstv_pkg::LX_NUM;
        p_neg = (c == "-");
        p_accum = (c == "-") ? 36'd0 : 36'(c - "0");
      end
    end else if (c == "[") open_nest(jstv_pkg::COL_ARR, jstv_pkg::EV_OPEN_ARR);
    else if (c == "{") open_nest(jstv_pkg::COL_OBJ, jstv_pkg::EV_OPEN_OBJ);
    else if (c == "]" || c == "}") begin
      if (p_level == 0) flag_error();
      else begin
        p_level--;
        p_state = jstv_pkg::pstate_t'(p_stack[p_level]);
        add_event(jstv_pkg::EV_CLOSE, 8'h00, 1'b0, 32'd0);
      end
    end else if (c == ":") begin
      if (p_state != jstv_pkg::PS_OBJVAL) flag_error();
    end else if (c == ",") begin
      nx = follow(p_state, jstv_pkg::COL_COMMA);
      if (nx == jstv_pkg::PS_BAD) flag_error();
      else p_state = nx;
    end else if (c == "t" || c == "T" || c == "f" || c == "F" || c == "n" || c == "N") begin
      if (follow(p_state, jstv_pkg::COL_INT) == jstv_pkg::PS_BAD) flag_error();
      else begin
        p_lit_sel = (c == "t" || c == "T") ? 0 : (c == "f" || c == "F") ? 1 : 2;
        p_lit_pos = 1;
        p_mode = jstv_pkg::LX_LIT;
      end
    end else if (c == "/") p_mode = jstv_pkg::LX_SLASH;
    else flag_error();
  endfunction

  function automatic logic [8:0] escape_value(logic [7:0] c);
    case (c)
      "\"": return 9'h22;
      "\\": return 9'h5C;
      "/":  return 9'h2F;
      "b":  return 9'h08;
      "f":  return 9'h0C;
      "n":  return 9'h0A;
      "r":  return 9'h0D;
      "t":  return 9'h09;
      default: return 9'h100;
    endcase
  endfunction

  function automatic void lex_byte(logic [7:0] c);
    logic key = (p_state == jstv_pkg::PS_OBJKEY);
    logic [8:0] m;
    logic [7:0] lc;
    string word;
    case (p_mode)
      jstv_pkg::LX_STR:
        if (c == "\\") p_mode = jstv_pkg::LX_ESC;
        else if (c == "\"") begin
          add_event(jstv_pkg::EV_STR_END, 8'h00, key, 32'd0);
          p_state = follow(p_state, jstv_pkg::COL_STR);
          p_mode = jstv_pkg::LX_IDLE;
        end else add_event(jstv_pkg::EV_STR_BYTE, c, key, 32'd0);
      jstv_pkg::LX_ESC: begin
        m = escape_value(c);
        if (m[8]) flag_error();
        else begin
          add_event(jstv_pkg::EV_STR_BYTE, m[7:0], key, 32'd0);
          p_mode = jstv_pkg::LX_STR;
        end
      end
      jstv_pkg::LX_NUM:
        if (c >= "0" && c <= "9") begin
          p_accum = p_accum * 36'd10 + 36'(c - "0");
          if (p_accum > 36'h80000000) p_accum = 36'h80000000;
        end else begin
          emit_value();
          p_state = follow(p_state, jstv_pkg::COL_INT);
          p_mode = jstv_pkg::LX_IDLE;
          begin_token(c);
        end
      jstv_pkg::LX_LIT: begin
        case (p_lit_sel)
          0: word = "true";
          1: word = "false";
          default: word = "null";
        endcase
        lc = (c >= "A" && c <= "Z") ? c + 8'd32 : c;
        if (p_lit_pos >= word.len() || lc != word[p_lit_pos]) flag_error();
        else begin
          p_lit_pos++;
          if (p_lit_pos == word.len()) begin
            add_event(jstv_pkg::event_t'(jstv_pkg::EV_TRUE + p_lit_sel), 8'h00, 1'b0, 32'd0);
            p_state = follow(p_state, jstv_pkg::COL_INT);
            p_mode = jstv_pkg::LX_IDLE;
          end
        end
      end
      jstv_pkg::LX_SLASH:
        if (c == "/") p_mode = jstv_pkg::LX_LINE;
        else if (c == "*") p_mode = jstv_pkg::LX_BLOCK;
        else flag_error();
      jstv_pkg::LX_LINE: if (c == "\n" || c == "\r") p_mode = jstv_pkg::LX_IDLE;
      jstv_pkg::LX_BLOCK: if (c == "*") p_mode = jstv_pkg::LX_STAR;
      jstv_pkg::LX_STAR:
        if (c == "/") p_mode = jstv_pkg::LX_IDLE;
        else if (c != "*") p_mode = jstv_pkg::LX_BLOCK;
      default: begin
        p_mode = jstv_pkg::LX_IDLE;
        begin_token(c);
      end
    endcase
  endfunction

  function automatic void predict_events(logic [7:0] c, logic eod);
    logic bad = 0, had;
    step_events.delete();
    if (!p_err) lex_byte(c);
    if (eod) begin
      had = p_err;
      if (!had) begin
        if (p_mode == jstv_pkg::LX_NUM) emit_value();
        else if (p_mode inside {jstv_pkg::LX_STR, jstv_pkg::LX_ESC, jstv_pkg::LX_LIT,
                                jstv_pkg::LX_SLASH}) bad = 1;
        if (p_level != 0) bad = 1;
      end
      clear_parser();
      add_event((!had && bad) ? jstv_pkg::EV_ERROR : jstv_pkg::EV_DOC_END,
                8'h00, 1'b0, 32'd0);
    end
    if (step_events.size() > 0) step_events[step_events.size()-1].last = 1'b1;
    expected_events = {expected_events, step_events};
  endfunction

  // one byte; valid stays high back to back when no idle is drawn
  task automatic send_byte(logic [7:0] c, logic eod);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= c;
    s_axis_tlast <= eod;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    predict_events(c, eod);
  endtask

  task automatic send_text(string s, bit eod = 1);
    for (int i = 0; i < s.len(); i++) send_byte(s[i], eod && i == s.len() - 1);
  endtask

  task automatic settle();
    s_axis_tvalid <= 1'b0;
    while (expected_events.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // receiver and checker
  always @(posedge clk) begin
    token_event_t got, want;
    cycles++;
    if (cycles > 400000) begin
      $display("** json_stream_tokenizer_validator_top: FAILED **");
      $finish;
    end
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got = {m_axis_tdata[3:0], m_axis_tdata[11:4], m_axis_tdata[12],
             m_axis_tdata[44:13], m_axis_tdata[49:45], m_axis_tlast};
      if (expected_events.size() == 0) begin
        report("unexpected", got, '0);
      end else begin
        want = expected_events.pop_front();
        if (got != want) report("event", got, want);
      end
    end
    m_axis_tready <= !recv_hold && ($urandom_range(99) >= recv_idle_pct);
  end

  task automatic test_directed();
    send_text("[07,-,2147483648,-99999999999]");
    send_text("{\"k\":\"\\b\377\",\"x\":[TRUE,nuLL]}");
    send_text("/**/[2]/*");
    send_text("[\"\\q\"]");
    send_text("[fx]");
    send_text("]");
    send_text("[[");
    send_text("{1:2}");
    send_text("/x");
    send_text("nul");
    send_text("@");
    send_text("[[[[[[[[[[[[[[[[[");
  endtask

  function automatic string rand_value(int depth);
    string s;
    int n;
    case ($urandom_range(depth > 3 ? 4 : 6))
      0: s = $sformatf("%0d", $signed($urandom()));
      1: s = "\"ab\\n\"";
      2: s = ($urandom_range(1)) ? "tRue" : "false";
      3: s = "null";
      4: s = $sformatf("%0d", $urandom_range(999));
      5: begin
        n = $urandom_range(3);
        s = "[";
        for (int i = 0; i < n; i++) s = {s, (i ? ", " : ""), rand_value(depth + 1)};
        s = {s, "]"};
      end
      default: begin
        n = $urandom_range(2);
        s = "{";
        for (int i = 0; i < n; i++)
          s = {s, (i ? "," : ""), "\"k", string'(8'("a" + i)), "\":", rand_value(depth + 1)};
        s = {s, "}"};
      end
    endcase
    return s;
  endfunction

  task automatic test_random(int count);
    string s;
    int sent = 0;
    while (sent < count) begin
      if ($urandom_range(9) < 8) begin
        s = rand_value(0);
        if ($urandom_range(9) == 0) s = {s, "/*z*/"};
        send_text(s);
        sent += s.len();
      end else begin
        // noise bytes, random full-range values
        for (int i = 0; i < 6; i++) send_byte(8'($urandom()), i == 5);
        sent += 6;
      end
    end
  endtask

  task automatic test_backpressure();
    recv_hold = 1;
    fork
      begin
        repeat (300) @(posedge clk);
        recv_hold = 0;
      end
      send_text("[\"abc\",true]");
    join
    settle();
  endtask

  initial begin
    clear_parser();
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    send_idle_pct = 22; recv_idle_pct = 67;
    test_directed();
    settle();
    test_random(12);
    settle();
    send_idle_pct = 67; recv_idle_pct = 22;
    test_random(12);
    settle();
    send_idle_pct = 0; recv_idle_pct = 0;
    test_random(12);
    settle();
    test_backpressure();
    if (errors == 0) $display("** json_stream_tokenizer_validator_top: PASSED **");
    else $display("** json_stream_tokenizer_validator_top: FAILED **");
    $finish;
  end
endmodule

FILE: sim.f
rtl/jstv_pkg.sv
rtl/json_stream_tokenizer_validator_top.sv
tb/json_stream_tokenizer_validator_top_test.sv
